FILE: hw/rtl/pausable_backoff_timer_assert.svh
// assertion macros shared by the backoff timer checkers
`ifndef PAUSABLE_BACKOFF_TIMER_ASSERT_SVH
`define PAUSABLE_BACKOFF_TIMER_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define PBT_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("backoff timer check failed");

// condition holds in the cycle after the trigger
`define PBT_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("backoff timer check failed");

`endif

FILE: hw/rtl/pbt_pkg.sv
// types and constants of the pausable backoff timer
package pbt_pkg;

   localparam int COUNT_BITS = 20;
   localparam int OP_W       = 3;
   localparam int DELAY_W    = 20;
   localparam int SLOT_W     = 16;
   localparam int REM_OUT_W  = 20;

   localparam int CMP_W = (COUNT_BITS > DELAY_W) ? COUNT_BITS : DELAY_W;
   localparam int SUM_W = ((COUNT_BITS > SLOT_W) ? COUNT_BITS : SLOT_W) + 1;
   localparam int CNT_W = $clog2(COUNT_BITS + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 3'd0,
      OP_START  = 3'd1,
      OP_PAUSE  = 3'd2,
      OP_RESUME = 3'd3,
      OP_STOP   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_READY,
      ST_DIVIDE,
      ST_ROUND
   } state_type;

   typedef struct packed {
      logic exec;
      logic div_start;
      logic div_step;
      logic round;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic need_div;
      logic div_last;
   } status_type;

endpackage

FILE: hw/rtl/pbt_req_if.sv
// command channel of the backoff timer
interface pbt_req_if;
   import pbt_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    opcode;
   logic [DELAY_W-1:0] delay_us;
   logic               has_stamp;
   logic [DELAY_W-1:0] elapsed_us;
   logic [SLOT_W-1:0]  slot_us;

   modport source (output valid, opcode, delay_us, has_stamp, elapsed_us, slot_us,
                   input ready);
   modport sink   (input valid, opcode, delay_us, has_stamp, elapsed_us, slot_us,
                   output ready);
endinterface

FILE: hw/rtl/pbt_rsp_if.sv
// result channel of the backoff timer
interface pbt_rsp_if;
   import pbt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 fired;
   logic                 immediate;
   logic [REM_OUT_W-1:0] remaining_us;
   logic                 running;
   logic                 paused;

   modport source (output valid, fired, immediate, remaining_us, running, paused,
                   input ready);
   modport sink   (input valid, fired, immediate, remaining_us, running, paused,
                   output ready);
endinterface

FILE: hw/rtl/pausable_backoff_timer.sv
// the result of an accepted transaction is registered in the output register
// throughput: one transaction per cycle for tick, start, pause, stop and plain resume while the output register is free
// a resume from pause with a nonzero count and slot runs through the divide and round states and takes no new
// transaction until done; the remainder unit forms one bit of count mod slot per cycle
// synchronous reset clears the count, the running and paused flags and the output valid
module pausable_backoff_timer (
   input  logic   clock,
   input  logic   reset,
   pbt_req_if.sink   req,
   pbt_rsp_if.source rsp
);
   import pbt_pkg::*;

   cmd_type    cmd;
   status_type status;

   pbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pbt_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_opcode     (req.opcode),
      .req_delay_us   (req.delay_us),
      .req_has_stamp  (req.has_stamp),
      .req_elapsed_us (req.elapsed_us),
      .req_slot_us    (req.slot_us),
      .cmd            (cmd),
      .status         (status),
      .rsp            (rsp)
   );

endmodule

FILE: hw/rtl/pbt_ctrl.sv
// sequencing state machine of the backoff timer
module pbt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pbt_pkg::status_type status,
   output pbt_pkg::cmd_type    cmd
);
   import pbt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_READY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_READY: begin
            if (req_valid && status.out_free && status.need_div) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (status.out_free) state_in = ST_READY;
         end
         default: state_in = ST_READY;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_READY: begin
            req_ready     = status.out_free;
            cmd.exec      = req_valid && status.out_free && !status.need_div;
            cmd.div_start = req_valid && status.out_free && status.need_div;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_ROUND: begin
            cmd.round = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

FILE: hw/rtl/pbt_dp.sv
// count state, slot remainder unit and result register of the backoff timer
module pbt_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [pbt_pkg::OP_W-1:0]     req_opcode,
   input  logic [pbt_pkg::DELAY_W-1:0]  req_delay_us,
   input  logic                         req_has_stamp,
   input  logic [pbt_pkg::DELAY_W-1:0]  req_elapsed_us,
   input  logic [pbt_pkg::SLOT_W-1:0]   req_slot_us,
   input  pbt_pkg::cmd_type             cmd,
   output pbt_pkg::status_type          status,
   pbt_rsp_if.source                    rsp
);
   import pbt_pkg::*;

   logic [COUNT_BITS-1:0] remaining_ff, remaining_in;
   logic                  counting_ff, counting_in;
   logic                  held_ff, held_in;

   logic [SLOT_W-1:0]     slot_ff;
   logic [COUNT_BITS-1:0] dividend_ff;
   logic [SLOT_W-1:0]     part_ff;
   logic [CNT_W-1:0]      cnt_ff;

   logic                  out_valid_ff, out_valid_in;
   logic                  out_fired_ff, out_fired_in;
   logic                  out_immediate_ff, out_immediate_in;
   logic [REM_OUT_W-1:0]  out_remaining_ff;
   logic                  out_running_ff;
   logic                  out_paused_ff;

   logic [CMP_W-1:0]      delay_wide, delay_clamp, elapsed_wide, start_val;
   logic                  start_imm;
   logic [SLOT_W:0]       trial;
   logic                  trial_ge;
   logic [SLOT_W-1:0]     part_next;
   logic [SUM_W-1:0]      round_sum;
   logic [COUNT_BITS-1:0] round_val;
   logic                  load;

   // start value: delay clamped to the count, less the stamp age
   always_comb begin
      delay_wide   = CMP_W'(req_delay_us);
      delay_clamp  = (delay_wide > CMP_W'(COUNT_MAX)) ? CMP_W'(COUNT_MAX) : delay_wide;
      elapsed_wide = CMP_W'(req_elapsed_us);
      start_imm    = req_has_stamp && (elapsed_wide >= delay_clamp);
      if (!req_has_stamp) begin
         start_val = delay_clamp;
      end else if (start_imm) begin
         start_val = '0;
      end else begin
         start_val = delay_clamp - elapsed_wide;
      end
   end

   // one remainder bit per step, msb of the count first
   always_comb begin
      trial     = {part_ff, dividend_ff[COUNT_BITS-1]};
      trial_ge  = trial >= {1'b0, slot_ff};
      part_next = trial_ge ? SLOT_W'(trial - {1'b0, slot_ff}) : trial[SLOT_W-1:0];
   end

   // next whole slot above the count is count - (count mod slot) + slot
   always_comb begin
      round_sum = SUM_W'(remaining_ff) - SUM_W'(part_ff) + SUM_W'(slot_ff);
      round_val = (round_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : round_sum[COUNT_BITS-1:0];
   end

   always_comb begin
      status.out_free = !out_valid_ff || rsp.ready;
      status.need_div = (req_opcode == OP_RESUME) && held_ff &&
                        (remaining_ff != '0) && (req_slot_us != '0);
      status.div_last = (cnt_ff == CNT_W'(1));
   end

   always_comb begin
      remaining_in     = remaining_ff;
      counting_in      = counting_ff;
      held_in          = held_ff;
      out_fired_in     = 1'b0;
      out_immediate_in = 1'b0;
      if (cmd.exec) begin
         unique case (req_opcode)
            OP_TICK: begin
               if (counting_ff) begin
                  if (remaining_ff <= COUNT_BITS'(1)) begin
                     remaining_in = '0;
                     counting_in  = 1'b0;
                     out_fired_in = 1'b1;
                  end else begin
                     remaining_in = remaining_ff - COUNT_BITS'(1);
                  end
               end
            end
            OP_START: begin
               held_in          = 1'b0;
               counting_in      = 1'b1;
               remaining_in     = start_val[COUNT_BITS-1:0];
               out_immediate_in = start_imm;
            end
            OP_PAUSE: begin
               counting_in = 1'b0;
               held_in     = 1'b1;
            end
            OP_RESUME: begin
               // rounded resume never reaches here
               if (held_ff) begin
                  out_immediate_in = (remaining_ff == '0);
                  held_in          = 1'b0;
                  counting_in      = 1'b1;
               end
            end
            OP_STOP: begin
               remaining_in = '0;
               counting_in  = 1'b0;
               held_in      = 1'b0;
            end
            default: begin
               remaining_in = remaining_ff;
            end
         endcase
      end else if (cmd.round) begin
         remaining_in = round_val;
         held_in      = 1'b0;
         counting_in  = 1'b1;
      end
   end

   assign load         = cmd.exec || cmd.round;
   assign out_valid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         remaining_ff <= '0;
         counting_ff  <= 1'b0;
         held_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         remaining_ff <= remaining_in;
         counting_ff  <= counting_in;
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
         if (cmd.div_start) begin
            cnt_ff <= CNT_W'(COUNT_BITS);
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         slot_ff     <= req_slot_us;
         dividend_ff <= remaining_ff;
         part_ff     <= '0;
      end else if (cmd.div_step) begin
         dividend_ff <= {dividend_ff[COUNT_BITS-2:0], 1'b0};
         part_ff     <= part_next;
      end
      if (load) begin
         out_fired_ff     <= out_fired_in;
         out_immediate_ff <= out_immediate_in;
         out_remaining_ff <= REM_OUT_W'(remaining_in);
         out_running_ff   <= counting_in;
         out_paused_ff    <= held_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.fired        = out_fired_ff;
   assign rsp.immediate    = out_immediate_ff;
   assign rsp.remaining_us = out_remaining_ff;
   assign rsp.running      = out_running_ff;
   assign rsp.paused       = out_paused_ff;

endmodule

FILE: hw/rtl/pbt_checker.sv
// port-level checks of the backoff timer and their binding
`include "pausable_backoff_timer_assert.svh"

module pbt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_fired,
   input logic        rsp_immediate,
   input logic [19:0] rsp_remaining_us,
   input logic        rsp_running,
   input logic        rsp_paused
);

   // an expiring tick leaves the timer stopped at zero
   `PBT_ASSERT_SAME(fire_stops, clock, reset, rsp_valid && rsp_fired, !rsp_running && !rsp_paused && rsp_remaining_us == 20'd0)

   // counting and frozen are exclusive
   `PBT_ASSERT_SAME(run_not_paused, clock, reset, rsp_valid && rsp_running, !rsp_paused)

   // immediate expiry leaves a running timer at zero that has not yet fired
   `PBT_ASSERT_SAME(imm_zero, clock, reset, rsp_valid && rsp_immediate, rsp_running && !rsp_fired && rsp_remaining_us == 20'd0)

   // a stalled result transaction holds
   `PBT_ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_remaining_us) && $stable(rsp_fired) && $stable(rsp_immediate))

endmodule

bind pausable_backoff_timer pbt_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_fired        (rsp.fired),
   .rsp_immediate    (rsp.immediate),
   .rsp_remaining_us (rsp.remaining_us),
   .rsp_running      (rsp.running),
   .rsp_paused       (rsp.paused)
);
